// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of the address pool allocator.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Boolean condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== design/ipa_pkg.sv =====
// Package for the address pool allocator: beat types, status codes, register indexes.
// Used by ip_block_pool_allocator and ipa_checker; depends on nothing.
package ipa_pkg;

  localparam int BLK_W      = 5;
  localparam int CNT_W      = 9;
  localparam int TOTAL_W    = 9;
  localparam int STATUS_W   = 3;
  localparam int HOST_NUM_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int HOST_STRIDE = 50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL  = 2'd0,
    CFG_BLOCKS = 2'd1,
    CFG_OCTET  = 2'd2
  } ipa_cfg_e;

  localparam logic [TOTAL_W-1:0] TOTAL_RST  = 9'd256;
  localparam logic [BLK_W-1:0]   BLOCKS_RST = 5'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_BAD_BLOCK = 3'd1,
    ST_BAD_COUNT = 3'd2,
    ST_TOO_SMALL = 3'd3,
    ST_NONE_FREE = 3'd4
  } ipa_status_e;

  typedef struct packed {
    logic [BLK_W-1:0] block_number;
    logic [CNT_W-1:0] count_required;
  } ipa_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [HOST_NUM_W-1:0] host_number;
    logic                  last;
  } ipa_res_t;

endpackage

// ===== design/ip_block_pool_allocator.sv =====
// Address pool allocator built around a serial divide for the block size.
// Rejected requests give one result beat the cycle after start, and busy never rises.
// Otherwise the divide, the S_DIV state taking its quotient and the S_CHECK state
// put out a status beat, or the granted hosts one beat per cycle from S_SCAN, the
// last flagged; busy drops as the final beat shows.
// Asynchronous active-low reset gives default registers and an empty pool; no stalls.
module ip_block_pool_allocator #(
  parameter int MAX_BLOCKS = 16,
  parameter int MAX_ADDRS  = 256,
  parameter int MAX_GRANT  = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  ipa_pkg::ipa_req_t                   req_i,
  output logic                                res_valid_o,
  output ipa_pkg::ipa_res_t                   res_o,
  input  logic                                cfg_we_i,
  input  logic [ipa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ipa_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import ipa_pkg::*;

  localparam int TW     = $clog2(MAX_ADDRS + 1);
  localparam int BW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int GW     = $clog2(MAX_GRANT + 1);
  localparam int WW     = (TW > CNT_W) ? TW : CNT_W;
  localparam int HOST_W = 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_SCAN
  } state_e;

  state_e             state_q;
  logic [TOTAL_W-1:0] total_q;
  logic [BLK_W-1:0]   blocks_q;
  logic [BW-1:0]      idx_q;
  logic [GW-1:0]      want_q;
  logic [GW-1:0]      left_q;
  logic [TW-1:0]      size_q;
  logic [TW-1:0]      slot_q;
  logic               res_valid_q;
  ipa_res_t           res_q;

  // Grants always take the lowest free slots, so each block's used slots form a
  // prefix and one fill count per block stands for its whole used map.
  logic [TW-1:0]      fill_q [MAX_BLOCKS];

  logic [BLK_W-1:0]   eff_n;
  logic [TW-1:0]      eff_t;
  logic               accept;
  logic               bad_block;
  logic               bad_count;
  logic               div_start;
  logic               div_done;
  logic [TW-1:0]      div_quot;
  logic [BLK_W-1:0]   div_rem;
  logic               idx_lt_rem;
  logic [TW-1:0]      fill_cur;
  logic [TW-1:0]      slot_nx;
  logic               grant_last;
  logic [HOST_W-1:0]  host_full;
  logic               map_clear;
  logic               fill_we;

  always_comb begin
    if (blocks_q == '0) begin
      eff_n = BLK_W'(1);
    end else if (blocks_q > BLK_W'(MAX_BLOCKS)) begin
      eff_n = BLK_W'(MAX_BLOCKS);
    end else begin
      eff_n = blocks_q;
    end
    if (total_q == '0) begin
      eff_t = TW'(1);
    end else if (WW'(total_q) > WW'(MAX_ADDRS)) begin
      eff_t = TW'(MAX_ADDRS);
    end else begin
      eff_t = TW'(total_q);
    end
  end

  assign busy       = (state_q != S_IDLE);
  assign accept     = start && !busy;
  assign bad_block  = (req_i.block_number == '0) || (req_i.block_number > eff_n);
  assign bad_count  = (req_i.count_required == '0) ||
                      (WW'(req_i.count_required) > WW'(MAX_GRANT));
  assign div_start  = accept && !bad_block && !bad_count;
  assign idx_lt_rem = (WW'(idx_q) < WW'(div_rem));
  assign fill_cur   = fill_q[idx_q];
  assign slot_nx    = slot_q + TW'(1);
  assign grant_last = (left_q == GW'(1)) || (slot_nx == size_q);
  assign host_full  = HOST_W'(idx_q) * HOST_W'(HOST_STRIDE) + HOST_W'(slot_q) + HOST_W'(1);
  // Any known register index clears the map, the octet index included.
  assign map_clear  = cfg_we_i && ((cfg_idx_i == CFG_TOTAL) || (cfg_idx_i == CFG_BLOCKS) ||
                                   (cfg_idx_i == CFG_OCTET));
  assign fill_we    = (state_q == S_SCAN);

  ipa_div #(
    .DW (TW),
    .VW (BLK_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (eff_t),
    .divisor_i  (eff_n),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= TOTAL_RST;
      blocks_q <= BLOCKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOTAL:  total_q  <= cfg_data_i[TOTAL_W-1:0];
        CFG_BLOCKS: blocks_q <= cfg_data_i[BLK_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (map_clear) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (fill_we) begin
      fill_q[idx_q] <= slot_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      want_q      <= '0;
      left_q      <= '0;
      size_q      <= '0;
      slot_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q  <= BW'(req_i.block_number - BLK_W'(1));
            want_q <= GW'(req_i.count_required);
            if (bad_block) begin
              res_valid_q <= 1'b1;
              res_q       <= '{status: ST_BAD_BLOCK, host_number: '0, last: 1'b1};
            end else if (bad_count) begin
              res_valid_q <= 1'b1;
              res_q       <= '{status: ST_BAD_COUNT, host_number: '0, last: 1'b1};
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            // The first total-modulo-block-count blocks hold one extra slot.
            size_q  <= div_quot + TW'(idx_lt_rem);
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (WW'(want_q) > WW'(size_q)) begin
            res_valid_q <= 1'b1;
            res_q       <= '{status: ST_TOO_SMALL, host_number: '0, last: 1'b1};
            state_q     <= S_IDLE;
          end else if (fill_cur == size_q) begin
            res_valid_q <= 1'b1;
            res_q       <= '{status: ST_NONE_FREE, host_number: '0, last: 1'b1};
            state_q     <= S_IDLE;
          end else begin
            slot_q  <= fill_cur;
            left_q  <= want_q;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          res_valid_q <= 1'b1;
          res_q       <= '{status: ST_GRANTED, host_number: host_full[HOST_NUM_W-1:0],
                           last: grant_last};
          slot_q      <= slot_nx;
          left_q      <= left_q - GW'(1);
          if (grant_last) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/ipa_div.sv =====
// Restoring divider, one quotient bit per cycle, for the block size calculation.
// Stand-alone; the allocator top level instantiates it.
module ipa_div #(
  parameter int DW = 9,
  parameter int VW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          run_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] div_q;

  logic [VW:0]   rem_s;
  logic          ge;
  logic [VW:0]   rem_sub;

  always_comb begin
    rem_s   = {rem_q, quo_q[DW-1]};
    ge      = (rem_s >= {1'b0, div_q});
    rem_sub = rem_s - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(DW - 1);
        quo_q <= dividend_i;
        rem_q <= '0;
        div_q <= divisor_i;
      end else if (run_q) begin
        // The partial remainder stays below the divisor, so VW bits hold it.
        rem_q <= ge ? rem_sub[VW-1:0] : rem_s[VW-1:0];
        quo_q <= {quo_q[DW-2:0], ge};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/ipa_checker.sv =====
// Port-level checker for the address pool allocator, bound to the top level.
// Depends on ipa_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module ipa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              res_valid_o,
  input ipa_pkg::ipa_res_t res_o
);
  import ipa_pkg::*;

  // An accepted request either rejects at once or keeps the block busy.
  `ASSERT_PROP(a_accept_reacts, clk_i, rst_ni, (start && !busy) |=> (busy || res_valid_o), "accepted request had no effect")

  // Every result beat follows an accepted request or busy work.
  `ASSERT_PROP(a_beat_has_cause, clk_i, rst_ni, res_valid_o |-> ($past(busy) || $past(start)), "result beat without a request")

  // Only the final beat of a request releases busy.
  `ASSERT_PROP(a_last_frees, clk_i, rst_ni, res_valid_o |-> (res_o.last == !busy), "last flag and busy disagree")

  // Error and status beats carry no host and close the request.
  `ASSERT_NEVER(a_error_form, clk_i, rst_ni, res_valid_o && (res_o.status != ST_GRANTED) && (!res_o.last || (res_o.host_number != '0)), "malformed status beat")

endmodule

bind ip_block_pool_allocator ipa_checker u_ipa_checker (.*);
